// ===== sv/papg_pkg.sv =====
// papg_pkg: shared constants, codes and types of the phased array pwm pattern generator
// no dependencies
package papg_pkg;

    localparam int CHANNELS    = 16;
    localparam int LEVEL_W     = 16;
    localparam int SAMPLE_W    = 5;
    localparam int BYTE_W      = 8;
    localparam int LOAD_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int OUT_CH      = (CHANNELS < LEVEL_W) ? CHANNELS : LEVEL_W;

    localparam logic [BYTE_W-1:0] TOP       = 8'd30;
    localparam logic [BYTE_W-1:0] AMP_RESET = 8'd15;
    localparam logic [BYTE_W-1:0] CMD_PHASE = 8'd254;
    localparam logic [BYTE_W-1:0] CMD_AMP   = 8'd251;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_PHASE = 2'd1;
    localparam logic [1:0] MODE_AMP   = 2'd2;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_BYTE = 1'b1;

    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_ERROR   = 1'b1;

    typedef logic [CHANNELS-1:0][BYTE_W-1:0] t_table;

    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] data;
    } t_parse_req;

endpackage

// ===== sv/papg_cmd_parser.sv =====
// papg_cmd_parser: serial command parser with staging buffer and phase/amplitude tables
// depends on papg_pkg
module papg_cmd_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  papg_pkg::t_parse_req i_req,
    output logic               o_err,
    output papg_pkg::t_table   o_phase,
    output papg_pkg::t_table   o_amp
);

    logic [1:0]                   r_mode;
    logic [1:0]                   n_mode;
    logic [papg_pkg::LOAD_W-1:0]  r_count;
    logic [papg_pkg::LOAD_W-1:0]  n_count;
    logic [papg_pkg::BYTE_W-1:0]  r_stage [papg_pkg::CHANNELS];
    papg_pkg::t_table             r_phase;
    papg_pkg::t_table             r_amp;
    papg_pkg::t_table             w_commit;
    logic                         w_loading;
    logic                         w_last;

    assign w_loading = (r_mode == papg_pkg::MODE_PHASE) || (r_mode == papg_pkg::MODE_AMP);
    assign w_last    = (r_count == papg_pkg::LOAD_W'(papg_pkg::CHANNELS - 1));

    always_comb begin
        for (int c = 0; c < papg_pkg::CHANNELS; c++) begin
            w_commit[c] = (c == papg_pkg::CHANNELS - 1) ? i_req.data : r_stage[c];
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        o_err   = 1'b0;
        if (i_req.en) begin
            if (w_loading) begin
                if (w_last) begin
                    n_mode  = papg_pkg::MODE_IDLE;
                    n_count = '0;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end else begin
                n_count = '0;
                priority if (i_req.data == papg_pkg::CMD_PHASE) begin
                    n_mode = papg_pkg::MODE_PHASE;
                end else if (i_req.data == papg_pkg::CMD_AMP) begin
                    n_mode = papg_pkg::MODE_AMP;
                end else begin
                    n_mode = papg_pkg::MODE_IDLE;
                    o_err  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= papg_pkg::MODE_IDLE;
            r_count <= '0;
            for (int c = 0; c < papg_pkg::CHANNELS; c++) begin
                r_phase[c] <= '0;
                r_amp[c]   <= papg_pkg::AMP_RESET;
            end
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
            if (i_req.en && w_loading && w_last) begin
                if (r_mode == papg_pkg::MODE_PHASE) begin
                    r_phase <= w_commit;
                end else begin
                    r_amp <= w_commit;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.en && w_loading) begin
            r_stage[r_count] <= i_req.data;
        end
    end

    assign o_phase = r_phase;
    assign o_amp   = r_amp;

endmodule

// ===== sv/papg_pattern.sv =====
// papg_pattern: per-channel pwm level compare for one sample position
// depends on papg_pkg
module papg_pattern (
    input  logic [papg_pkg::SAMPLE_W-1:0] i_sample,
    input  papg_pkg::t_table              i_phase,
    input  papg_pkg::t_table              i_amp,
    output logic [papg_pkg::LEVEL_W-1:0]  o_levels
);

    for (genvar c = 0; c < papg_pkg::LEVEL_W; c++) begin : g_ch
        if (c < papg_pkg::OUT_CH) begin : g_on
            logic [papg_pkg::SAMPLE_W-1:0] w_pos;
            logic [papg_pkg::BYTE_W-1:0]   w_lo;
            assign w_pos = i_sample + i_phase[c][papg_pkg::SAMPLE_W-1:0];
            assign w_lo  = papg_pkg::TOP - i_amp[c];
            assign o_levels[c] = (i_amp[c] <= papg_pkg::TOP)
                && (papg_pkg::BYTE_W'(w_pos) > w_lo)
                && (papg_pkg::BYTE_W'(w_pos) < papg_pkg::TOP);
        end else begin : g_off
            assign o_levels[c] = 1'b0;
        end
    end

endmodule

// ===== sv/phased_array_pwm_pattern_generator.sv =====
// phased_array_pwm_pattern_generator: top level, input register, sample counter, result register
// depends on papg_pkg, papg_cmd_parser, papg_pattern
// result: registered in the result register from the item held in the input register
// throughput: one item per cycle; input stalls only while the result register is held
// reset: synchronous active low; counter, parser and tables go to reset values
module phased_array_pwm_pattern_generator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_cmd,
    input  logic [papg_pkg::BYTE_W-1:0]   i_rx_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_kind,
    output logic [papg_pkg::LEVEL_W-1:0]  o_levels,
    output logic [papg_pkg::SAMPLE_W-1:0] o_sample_index
);

    logic                          r_in_valid;
    logic                          r_in_cmd;
    logic [papg_pkg::BYTE_W-1:0]   r_in_byte;
    logic [papg_pkg::SAMPLE_W-1:0] r_sample;
    logic                          r_out_valid;
    logic                          r_out_kind;
    logic [papg_pkg::LEVEL_W-1:0]  r_out_levels;
    logic [papg_pkg::SAMPLE_W-1:0] r_out_index;
    logic                          w_adv;
    logic                          w_go;
    logic                          w_tick;
    logic                          w_err;
    logic [papg_pkg::LEVEL_W-1:0]  w_levels;
    papg_pkg::t_parse_req          w_req;
    papg_pkg::t_table              w_phase;
    papg_pkg::t_table              w_amp;

    assign w_adv   = !r_out_valid || !i_stall;
    assign w_go    = r_in_valid && w_adv;
    assign w_tick  = w_go && (r_in_cmd == papg_pkg::CMD_TICK);
    assign o_stall = r_in_valid && !w_adv;

    assign w_req.en   = w_go && (r_in_cmd == papg_pkg::CMD_BYTE);
    assign w_req.data = r_in_byte;

    papg_cmd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_err   (w_err),
        .o_phase (w_phase),
        .o_amp   (w_amp)
    );

    papg_pattern u_pattern (
        .i_sample (r_sample),
        .i_phase  (w_phase),
        .i_amp    (w_amp),
        .o_levels (w_levels)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_sample    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (w_tick) begin
                r_sample <= r_sample + 1'b1;
            end
            if (w_adv) begin
                r_out_valid <= w_tick || w_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_cmd  <= i_cmd;
            r_in_byte <= i_rx_byte;
        end
        if (w_tick) begin
            r_out_kind   <= papg_pkg::KIND_PATTERN;
            r_out_levels <= w_levels;
            r_out_index  <= r_sample;
        end else if (w_go && w_err) begin
            r_out_kind   <= papg_pkg::KIND_ERROR;
            r_out_levels <= '0;
            r_out_index  <= '0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_levels       = r_out_levels;
    assign o_sample_index = r_out_index;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == papg_pkg::KIND_ERROR) |-> (o_levels == '0 && o_sample_index == '0))
        else $error("error item carries nonzero payload");

    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick |=> (o_valid && o_kind == papg_pkg::KIND_PATTERN && o_sample_index == $past(r_sample)))
        else $error("tick did not produce a pattern item");

    a_counter_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick |=> (r_sample == $past(r_sample) + 1'b1))
        else $error("sample counter did not advance");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && o_valid && i_stall))
        else $error("input stalled without a held result");

endmodule
